// File: src/descending_table_binary_search_macros.svh
// assertion macros shared by the search block modules
// no dependencies; included by files that carry concurrent checks
`ifndef DESCENDING_TABLE_BINARY_SEARCH_MACROS_SVH
`define DESCENDING_TABLE_BINARY_SEARCH_MACROS_SVH

// check disabled while reset is asserted
`define DTBS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that also holds across reset
`define DTBS_ASSERT_NR(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/dtbs_pkg.sv
// shared widths, operation codes and controller/datapath interface types
// no dependencies
`timescale 1ns / 1ps

package dtbs_pkg;

  localparam int unsigned LEN_W         = 9;
  localparam int unsigned IDX_W         = 8;
  localparam int unsigned ID_W          = 32;
  localparam int unsigned TGT_W         = 64;
  localparam int unsigned DEFAULT_DEPTH = 256;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef struct packed {
    logic write;
    logic start;
    logic probe;
    logic finish;
    logic finish_empty;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic hit;
    logic last;
    logic out_free;
  } dp_status_t;

endpackage

// File: src/descending_table_binary_search.sv
// channel | dir | fields                                              | handshake
// input   | in  | func, entry_index, entry_id, entry_target, query_id | in_valid_i / in_stall_o
// output  | out | found, target                                       | out_valid_o / out_stall_i
// config  | in  | table_length                                        | cfg_we_i, no wait
// a table write completes with its input transfer; a lookup reads the table once for each probe,
// at most log2(table_length)+1 probes (9 at 256 entries), each compared on the registered table read
// an empty table skips the table read and loads a miss from ST_EMPTY once the output is free
// the input is stalled while a lookup runs; a result waiting on out_stall_i holds the last probe
// reset clears table_length, the bounds and the control state; table contents are not reset
`timescale 1ns / 1ps

module descending_table_binary_search #(
  parameter int unsigned TABLE_DEPTH = dtbs_pkg::DEFAULT_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [dtbs_pkg::LEN_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       func_i,
  input  logic [dtbs_pkg::IDX_W-1:0] entry_index_i,
  input  logic [dtbs_pkg::ID_W-1:0]  entry_id_i,
  input  logic [dtbs_pkg::TGT_W-1:0] entry_target_i,
  input  logic [dtbs_pkg::ID_W-1:0]  query_id_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       found_o,
  output logic [dtbs_pkg::TGT_W-1:0] target_o
);

  dtbs_pkg::dp_cmd_t    cmd;
  dtbs_pkg::dp_status_t status;

  dtbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dtbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .entry_index_i  (entry_index_i),
    .entry_id_i     (entry_id_i),
    .entry_target_i (entry_target_i),
    .query_id_i     (query_id_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .target_o       (target_o)
  );

endmodule

// File: src/dtbs_ctrl.sv
// search sequencer: accepts transfers, steps probes, hands results to the datapath
// depends on dtbs_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "descending_table_binary_search_macros.svh"

module dtbs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 func_i,
  input  dtbs_pkg::dp_status_t status_i,
  output dtbs_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_EMPTY  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   in_xfer;
  logic   search_done;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign search_done = status_i.hit || status_i.last;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (func_i == dtbs_pkg::FUNC_WRITE) begin
            cmd_o.write = 1'b1;
          end else if (status_i.empty) begin
            state_d = ST_EMPTY;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (!search_done) begin
          cmd_o.probe = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (status_i.out_free) begin
          cmd_o.finish_empty = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `DTBS_ASSERT(a_cmd_onehot0, clk_i, rst_ni, $onehot0(cmd_o), "more than one datapath command")
  `DTBS_ASSERT(a_table_write_idle, clk_i, rst_ni, cmd_o.write |-> !in_stall_o && in_valid_i,
               "table write outside an input transfer")

endmodule

// File: src/dtbs_datapath.sv
// table memories, search bounds, probe compare and result register
// depends on dtbs_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "descending_table_binary_search_macros.svh"

module dtbs_datapath #(
  parameter int unsigned TABLE_DEPTH = dtbs_pkg::DEFAULT_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [dtbs_pkg::LEN_W-1:0] cfg_wdata_i,
  input  logic [dtbs_pkg::IDX_W-1:0] entry_index_i,
  input  logic [dtbs_pkg::ID_W-1:0]  entry_id_i,
  input  logic [dtbs_pkg::TGT_W-1:0] entry_target_i,
  input  logic [dtbs_pkg::ID_W-1:0]  query_id_i,
  input  dtbs_pkg::dp_cmd_t          cmd_i,
  output dtbs_pkg::dp_status_t       status_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       found_o,
  output logic [dtbs_pkg::TGT_W-1:0] target_o
);

  localparam int unsigned LEN_W  = dtbs_pkg::LEN_W;
  localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned EXT_W  = (ADDR_W > LEN_W) ? ADDR_W : LEN_W;

  logic [dtbs_pkg::ID_W-1:0]  ids_mem [TABLE_DEPTH];
  logic [dtbs_pkg::TGT_W-1:0] tgts_mem [TABLE_DEPTH];

  logic [LEN_W-1:0]           table_length_q;
  logic [LEN_W-1:0]           eff_len;
  logic [LEN_W-1:0]           lo_q, hi_q, lo_d, hi_d;
  logic [LEN_W-1:0]           mid_q;
  logic [LEN_W-1:0]           lo_n, hi_n, mid_n, mid0, rd_mid;
  logic [LEN_W:0]             sum_n;
  logic [EXT_W-1:0]           raddr_ext, waddr_ext;
  logic [ADDR_W-1:0]          raddr, waddr;
  logic [dtbs_pkg::ID_W-1:0]  query_q;
  logic [dtbs_pkg::ID_W-1:0]  rd_id_q;
  logic [dtbs_pkg::TGT_W-1:0] rd_tgt_q;
  logic                       mem_we, rd_en;
  logic                       hit, query_gt;
  logic                       out_valid_q, found_q;
  logic [dtbs_pkg::TGT_W-1:0] target_q;
  logic                       out_free;

  // table_length above the table depth saturates
  assign eff_len = (32'(table_length_q) > 32'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH)
                                                             : table_length_q;

  // probe compare on the registered read data
  assign hit      = (query_q == rd_id_q);
  assign query_gt = (query_q > rd_id_q);
  assign lo_n     = query_gt ? lo_q : LEN_W'(mid_q + LEN_W'(1));
  assign hi_n     = query_gt ? mid_q : hi_q;
  assign sum_n    = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid_n    = sum_n[LEN_W:1];
  assign mid0     = eff_len >> 1;

  assign rd_en     = cmd_i.start || cmd_i.probe;
  assign rd_mid    = cmd_i.start ? mid0 : mid_n;
  assign raddr_ext = EXT_W'(rd_mid);
  assign raddr     = raddr_ext[ADDR_W-1:0];

  // writes past the table depth are dropped
  assign mem_we    = cmd_i.write && (32'(entry_index_i) < 32'(TABLE_DEPTH));
  assign waddr_ext = EXT_W'(entry_index_i);
  assign waddr     = waddr_ext[ADDR_W-1:0];

  assign out_free = !out_valid_q || !out_stall_i;

  assign status_o.empty    = (eff_len == '0);
  assign status_o.hit      = hit;
  assign status_o.last     = (lo_n == hi_n);
  assign status_o.out_free = out_free;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ids_mem[waddr] <= entry_id_i;
    end
    if (rd_en) begin
      rd_id_q <= ids_mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tgts_mem[waddr] <= entry_target_i;
    end
    if (rd_en) begin
      rd_tgt_q <= tgts_mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      query_q <= query_id_i;
    end
    if (rd_en) begin
      mid_q <= rd_mid;
    end
  end

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    priority if (cmd_i.start) begin
      lo_d = '0;
      hi_d = eff_len;
    end else if (cmd_i.probe || (cmd_i.finish && !hit)) begin
      lo_d = lo_n;
      hi_d = hi_n;
    end else if (cmd_i.finish_empty) begin
      lo_d = '0;
      hi_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_length_q <= '0;
      lo_q           <= '0;
      hi_q           <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        table_length_q <= cfg_wdata_i;
      end
      lo_q <= lo_d;
      hi_q <= hi_d;
      if (cmd_i.finish || cmd_i.finish_empty) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register, loaded on the last probe or for an empty table
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      found_q  <= hit;
      target_q <= hit ? rd_tgt_q : '0;
    end else if (cmd_i.finish_empty) begin
      found_q  <= 1'b0;
      target_q <= '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign target_o    = target_q;

  `DTBS_ASSERT(a_probe_in_bounds, clk_i, rst_ni, rd_en |=> (mid_q >= lo_q) && (mid_q < hi_q),
               "probe address outside the search bounds")
  `DTBS_ASSERT(a_no_result_overwrite, clk_i, rst_ni,
               (cmd_i.finish || cmd_i.finish_empty) |-> !(out_valid_q && out_stall_i),
               "result register overwritten while stalled")

endmodule

// File: test/descending_table_binary_search_tb.sv
// self-checking testbench for descending_table_binary_search: table writes, length settings and
// lookups, each result compared with a typed expected value or a local binary search over a shadow copy of the table
// depends on dtbs_pkg and the descending_table_binary_search module
`timescale 1ns / 1ps

module descending_table_binary_search_tb;

  localparam int unsigned LEN_W       = dtbs_pkg::LEN_W;
  localparam int unsigned IDX_W       = dtbs_pkg::IDX_W;
  localparam int unsigned ID_W        = dtbs_pkg::ID_W;
  localparam int unsigned TGT_W       = dtbs_pkg::TGT_W;
  localparam int unsigned DEPTH       = dtbs_pkg::DEFAULT_DEPTH;
  localparam int unsigned SETTLE      = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_WAIT    = 13;
  localparam int unsigned ITEM_GOAL   = 390;
  localparam int unsigned N_ROWS      = 23;

  typedef struct packed {
    logic             found;
    logic [TGT_W-1:0] target;
  } lookup_result_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_LOOKUP,
    ROW_LENGTH
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [LEN_W-1:0] length;
    logic [IDX_W-1:0] index;
    logic [ID_W-1:0]  id;
    logic [TGT_W-1:0] target;
    logic [ID_W-1:0]  query;
    logic             typed;
    lookup_result_t   result;
  } stim_row_t;

  localparam logic [TGT_W-1:0] ONES = {TGT_W{1'b1}};

  // typed results only where the answer is obvious from the table contents
  stim_row_t directed_rows [N_ROWS] = '{
    '{ROW_LOOKUP, 9'd0, 8'd0, 32'h0, 64'h0, 32'h0000_0000, 1'b1, '{1'b0, 64'h0}},
    '{ROW_LOOKUP, 9'd0, 8'd0, 32'h0, 64'h0, 32'hFFFF_FFFF, 1'b1, '{1'b0, 64'h0}},
    '{ROW_WRITE, 9'd0, 8'd0, 32'hFFFF_FFFF, ONES, 32'h0, 1'b0, '{1'b0, 64'h0}},
    '{ROW_WRITE, 9'd0, 8'd1, 32'h8000_0000, 64'h0, 32'h0, 1'b0, '{1'b0, 64'h0}},
    '{ROW_WRITE, 9'd0, 8'd2, 32'h0000_1234, 64'h0123_4567_89AB_CDEF, 32'h0, 1'b0,
      '{1'b0, 64'h0}},
    '{ROW_WRITE, 9'd0, 8'd3, 32'h0000_0000, 64'h8000_0000_0000_0001, 32'h0, 1'b0,
      '{1'b0, 64'h0}},
    '{ROW_LENGTH, 9'd4, 8'd0, 32'h0, 64'h0, 32'h0, 1'b0, '{1'b0, 64'h0}},
    '{ROW_LOOKUP, 9'd0, 8'd0, 32'h0, 64'h0, 32'hFFFF_FFFF, 1'b1, '{1'b1, ONES}},
    '{ROW_LOOKUP, 9'd0, 8'd0, 32'h0, 64'h0, 32'h0000_0000, 1'b1,
      '{1'b1, 64'h8000_0000_0000_0001}},
    '{ROW_LOOKUP, 9'd0, 8'd0, 32'h0, 64'h0, 32'h8000_0000, 1'b1, '{1'b1, 64'h0}},
    '{ROW_LOOKUP, 9'd0, 8'd0, 32'h0, 64'h0, 32'h0000_1234, 1'b0, '{1'b0, 64'h0}},
    '{ROW_LOOKUP, 9'd0, 8'd0, 32'h0, 64'h0, 32'h7FFF_FFFF, 1'b1, '{1'b0, 64'h0}},
    '{ROW_LOOKUP, 9'd0, 8'd0, 32'h0, 64'h0, 32'h0000_0001, 1'b1, '{1'b0, 64'h0}},
    '{ROW_LENGTH, 9'd1, 8'd0, 32'h0, 64'h0, 32'h0, 1'b0, '{1'b0, 64'h0}},
    '{ROW_LOOKUP, 9'd0, 8'd0, 32'h0, 64'h0, 32'h0000_0000, 1'b1, '{1'b0, 64'h0}},
    '{ROW_LOOKUP, 9'd0, 8'd0, 32'h0, 64'h0, 32'hFFFF_FFFF, 1'b1, '{1'b1, ONES}},
    // duplicate id breaks the descending order
    '{ROW_WRITE, 9'd0, 8'd1, 32'hFFFF_FFFF, 64'h5A5A_5A5A_5A5A_5A5A, 32'h0, 1'b0,
      '{1'b0, 64'h0}},
    '{ROW_WRITE, 9'd0, 8'd255, 32'h0000_0005, 64'hA5A5_A5A5_A5A5_A5A5, 32'h0, 1'b0,
      '{1'b0, 64'h0}},
    '{ROW_LENGTH, 9'd3, 8'd0, 32'h0, 64'h0, 32'h0, 1'b0, '{1'b0, 64'h0}},
    '{ROW_LOOKUP, 9'd0, 8'd0, 32'h0, 64'h0, 32'hFFFF_FFFF, 1'b0, '{1'b0, 64'h0}},
    '{ROW_LOOKUP, 9'd0, 8'd0, 32'h0, 64'h0, 32'h0000_1234, 1'b0, '{1'b0, 64'h0}},
    '{ROW_LENGTH, 9'd0, 8'd0, 32'h0, 64'h0, 32'h0, 1'b0, '{1'b0, 64'h0}},
    '{ROW_LOOKUP, 9'd0, 8'd0, 32'h0, 64'h0, 32'h0000_0000, 1'b1, '{1'b0, 64'h0}}
  };

  logic             clk          = 1'b0;
  logic             rst_n        = 1'b0;
  logic             cfg_we       = 1'b0;
  logic [LEN_W-1:0] cfg_wdata    = '0;
  logic             in_valid     = 1'b0;
  logic             in_stall;
  logic             func         = dtbs_pkg::FUNC_WRITE;
  logic [IDX_W-1:0] entry_index  = '0;
  logic [ID_W-1:0]  entry_id     = '0;
  logic [TGT_W-1:0] entry_target = '0;
  logic [ID_W-1:0]  query_id     = '0;
  logic             out_valid;
  logic             out_stall    = 1'b1;
  logic             found;
  logic [TGT_W-1:0] target;

  // shadow state of the block
  logic [ID_W-1:0]  shadow_ids     [DEPTH];
  logic [TGT_W-1:0] shadow_targets [DEPTH];
  int unsigned      shadow_length;

  lookup_result_t   pending_results [$];
  lookup_result_t   oldest;
  int unsigned      fail_count;
  int unsigned      cycle_count;
  int unsigned      lookups_total, hits_total, writes_total, length_writes;
  int unsigned      sorted_len;
  bit               steady;

  always #2 clk = ~clk;

  descending_table_binary_search #(
    .TABLE_DEPTH(DEPTH)
  ) DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .func_i        (func),
    .entry_index_i (entry_index),
    .entry_id_i    (entry_id),
    .entry_target_i(entry_target),
    .query_id_i    (query_id),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .found_o       (found),
    .target_o      (target)
  );

  // half-open search, probe at floor of the bounds' mean
  function automatic lookup_result_t search_table(logic [ID_W-1:0] qid);
    lookup_result_t res;
    int unsigned lo, hi, mid;
    res = '0;
    lo  = 0;
    hi  = (shadow_length > DEPTH) ? DEPTH : shadow_length;
    while (lo != hi) begin
      mid = (lo + hi) / 2;
      if (qid == shadow_ids[mid]) begin
        res.found  = 1'b1;
        res.target = shadow_targets[mid];
        break;
      end else if (qid > shadow_ids[mid]) begin
        hi = mid;
      end else begin
        lo = mid + 1;
      end
    end
    return res;
  endfunction

  // one input transfer; valid stays high on return so a zero gap needs no extra wait
  task automatic send_item(input logic fn, input logic [IDX_W-1:0] idx,
                           input logic [ID_W-1:0] eid, input logic [TGT_W-1:0] etgt,
                           input logic [ID_W-1:0] qid, input bit typed,
                           input lookup_result_t typed_result);
    int unsigned gap;
    lookup_result_t res;
    gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    func         <= fn;
    entry_index  <= idx;
    entry_id     <= eid;
    entry_target <= etgt;
    query_id     <= qid;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (fn == dtbs_pkg::FUNC_WRITE) begin
      shadow_ids[idx]     = eid;
      shadow_targets[idx] = etgt;
      writes_total++;
    end else begin
      res = typed ? typed_result : search_table(qid);
      pending_results.push_back(res);
      lookups_total++;
      hits_total += res.found;
    end
  endtask

  task automatic write_entry(input logic [IDX_W-1:0] idx, input logic [ID_W-1:0] eid);
    send_item(dtbs_pkg::FUNC_WRITE, idx, eid, {$urandom, $urandom}, $urandom, 1'b0, '0);
  endtask

  task automatic lookup_id(input logic [ID_W-1:0] qid);
    send_item(dtbs_pkg::FUNC_LOOKUP, IDX_W'($urandom), $urandom, {$urandom, $urandom}, qid,
              1'b0, '0);
  endtask

  // stop sending and let the block drain before touching the length register
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_length(input logic [LEN_W-1:0] len);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we        <= 1'b0;
    shadow_length = len;
    length_writes++;
  endtask

  // fresh strictly descending ids over entries 0..n-1, spread across the id range
  task automatic build_descending(input int unsigned n);
    longint unsigned span, cur;
    span = 64'hFFFF_FFFF / (n + 1);
    cur  = ($urandom_range(0, 9) == 0) ? 64'hFFFF_FFFF
                                       : 64'hFFFF_FFFF - $urandom_range(0, 32'(span - 1));
    for (int unsigned k = 0; k < n; k++) begin
      if (k > 0) cur = cur - 1 - $urandom_range(0, 32'(span - 1));
      write_entry(IDX_W'(k), cur[ID_W-1:0]);
    end
    sorted_len = n;
  endtask

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 16) return 1;
    if (r < 64) return $urandom_range(2, 16);
    if (r < 80) return $urandom_range(17, 64);
    if (r < 88) return $urandom_range(65, 255);
    if (r < 94) return DEPTH;
    return $urandom_range(DEPTH + 1, (1 << LEN_W) - 1);
  endfunction

  task automatic random_item(input int unsigned eff);
    int unsigned r, idx;
    logic [ID_W-1:0] qid;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      // stray write, may break the order of the searched range
      idx = $urandom_range(0, DEPTH - 1);
      if (idx < sorted_len) sorted_len = idx;
      write_entry(IDX_W'(idx), $urandom);
    end else begin
      if (eff > 0 && r < 55) begin
        qid = shadow_ids[$urandom_range(0, eff - 1)];
      end else if (eff > 0 && r < 70) begin
        qid = shadow_ids[$urandom_range(0, eff - 1)];
        qid = $urandom_range(0, 1) ? qid + 1 : qid - 1;
      end else if (r < 80) begin
        qid = $urandom_range(0, 1) ? '1 : '0;
      end else begin
        qid = $urandom;
      end
      lookup_id(qid);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no lookup pending: found=%0d target=%h", found, target);
        fail_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (found !== oldest.found) begin
          $error("found: expected %0d, actual %0d", oldest.found, found);
          fail_count++;
        end
        if (target !== oldest.target) begin
          $error("target: expected %h, actual %h", oldest.target, target);
          fail_count++;
        end
      end
    end
  end

  // receiver: random stall before each result transfer
  initial begin
    int unsigned hold;
    forever begin
      hold = steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned len, eff, n_items;
    fail_count    = 0;
    cycle_count   = 0;
    lookups_total = 0;
    hits_total    = 0;
    writes_total  = 0;
    length_writes = 0;
    shadow_length = 0;
    sorted_len    = 0;
    steady        = 1'b0;
    foreach (shadow_ids[i]) begin
      shadow_ids[i]     = '0;
      shadow_targets[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_LENGTH: begin
          settle_idle();
          set_length(directed_rows[i].length);
        end
        ROW_WRITE: begin
          send_item(dtbs_pkg::FUNC_WRITE, directed_rows[i].index, directed_rows[i].id,
                    directed_rows[i].target, directed_rows[i].query, 1'b0, '0);
        end
        default: begin
          send_item(dtbs_pkg::FUNC_LOOKUP, directed_rows[i].index, directed_rows[i].id,
                    directed_rows[i].target, directed_rows[i].query,
                    directed_rows[i].typed, directed_rows[i].result);
        end
      endcase
    end

    // random phases; the first one fills the whole table so later reads never hit unwritten rows
    // the second one uses a length beyond the table
    for (int phase = 0; writes_total + lookups_total < ITEM_GOAL; phase++) begin
      len    = (phase == 0) ? DEPTH
             : (phase == 1) ? $urandom_range(DEPTH + 1, (1 << LEN_W) - 1)
             : pick_length();
      eff    = (len > DEPTH) ? DEPTH : len;
      steady = (phase > 0) && ($urandom_range(0, 4) == 0);
      if (phase == 0) begin
        build_descending(DEPTH);
      end else if (eff > 0 && eff <= 16 && (eff > sorted_len || $urandom_range(0, 2) == 0)) begin
        build_descending(eff);
      end
      settle_idle();
      set_length(LEN_W'(len));
      n_items = $urandom_range(15, 40);
      repeat (n_items) random_item(eff);
    end

    settle_idle();
    fail_count += pending_results.size();
    $display("covered %0d lookups (%0d hits, %0d misses) and %0d table writes",
             lookups_total, hits_total, lookups_total - hits_total, writes_total);
    $display("over %0d table length settings, from empty through saturated",
             length_writes);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
